// ===== rtl/pgi_pkg.sv =====
// Shared types, constants and the step table of the palette gradient interpolator.
package pgi_pkg;

  localparam int PALETTE_DEPTH_DEF = 64;

  localparam int CNT_W      = 7;    // palette_count and index fields
  localparam int COLOUR_W   = 24;
  localparam int FRAC_W     = 17;
  localparam int POS_W      = 19;
  localparam int CTRL_W     = 19;
  localparam int IN_DATA_W  = 112;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [FRAC_W-1:0] T_ONE = 17'h10000;

  // shared multiplier and accumulator widths
  localparam int X_W       = 34;
  localparam int Y_W       = 19;
  localparam int PROD_W    = X_W + Y_W;
  localparam int ACC_W     = 54;
  localparam int W_W       = 33;   // bezier weights, 32 fraction bits, up to 2^32
  localparam int BEZ_SHIFT = 40;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLOUR = 1'd1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_POS   = 2'd1,
    ACT_LIN   = 2'd2,
    ACT_BEZ   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    X_T, X_U, X_PROD, X_U2, X_T2, X_W0, X_W1, X_W2, X_W3
  } xsel_t;

  typedef enum logic [2:0] {
    Y_T, Y_U, Y_DIFF, Y_A, Y_B, Y_CA, Y_CB
  } ysel_t;

  // what is done with the product issued in the previous step
  typedef enum logic [3:0] {
    P_NONE, P_U2, P_T2, P_W0, P_W1, P_W2, P_W3,
    P_ACC_FIRST, P_ACC_ADD, P_ACC_LAST, P_LIN
  } post_t;

  typedef struct packed {
    xsel_t      xsel;
    ysel_t      ysel;
    logic [1:0] ch;
    post_t      post;
    logic       last;
  } ustep_t;

  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] LIN_START = 5'd0;
  localparam logic [PC_W-1:0] BEZ_START = 5'd4;

  function automatic ustep_t mk(input xsel_t xs, input ysel_t ys, input logic [1:0] ch,
                                input post_t po, input logic last);
    ustep_t s;
    s.xsel = xs;
    s.ysel = ys;
    s.ch   = ch;
    s.post = po;
    s.last = last;
    return s;
  endfunction

  // linear blend: t*(b-a) per channel; bezier: weights, then 4 terms per channel
  function automatic ustep_t ucode(input logic [PC_W-1:0] pc);
    ustep_t s;
    case (pc)
      5'd0:    s = mk(X_T,    Y_DIFF, 2'd0, P_NONE,      1'b0);
      5'd1:    s = mk(X_T,    Y_DIFF, 2'd1, P_LIN,       1'b0);
      5'd2:    s = mk(X_T,    Y_DIFF, 2'd2, P_LIN,       1'b0);
      5'd3:    s = mk(X_T,    Y_T,    2'd2, P_LIN,       1'b1);
      5'd4:    s = mk(X_U,    Y_U,    2'd0, P_NONE,      1'b0);
      5'd5:    s = mk(X_PROD, Y_U,    2'd0, P_U2,        1'b0);
      5'd6:    s = mk(X_U2,   Y_T,    2'd0, P_W0,        1'b0);
      5'd7:    s = mk(X_T,    Y_T,    2'd0, P_W1,        1'b0);
      5'd8:    s = mk(X_PROD, Y_T,    2'd0, P_T2,        1'b0);
      5'd9:    s = mk(X_T2,   Y_U,    2'd0, P_W3,        1'b0);
      5'd10:   s = mk(X_W0,   Y_A,    2'd0, P_W2,        1'b0);
      5'd11:   s = mk(X_W1,   Y_CA,   2'd0, P_ACC_FIRST, 1'b0);
      5'd12:   s = mk(X_W2,   Y_CB,   2'd0, P_ACC_ADD,   1'b0);
      5'd13:   s = mk(X_W3,   Y_B,    2'd0, P_ACC_ADD,   1'b0);
      5'd14:   s = mk(X_W0,   Y_A,    2'd1, P_ACC_LAST,  1'b0);
      5'd15:   s = mk(X_W1,   Y_CA,   2'd1, P_ACC_FIRST, 1'b0);
      5'd16:   s = mk(X_W2,   Y_CB,   2'd1, P_ACC_ADD,   1'b0);
      5'd17:   s = mk(X_W3,   Y_B,    2'd1, P_ACC_ADD,   1'b0);
      5'd18:   s = mk(X_W0,   Y_A,    2'd2, P_ACC_LAST,  1'b0);
      5'd19:   s = mk(X_W1,   Y_CA,   2'd2, P_ACC_FIRST, 1'b0);
      5'd20:   s = mk(X_W2,   Y_CB,   2'd2, P_ACC_ADD,   1'b0);
      5'd21:   s = mk(X_W3,   Y_B,    2'd2, P_ACC_ADD,   1'b0);
      5'd22:   s = mk(X_T,    Y_T,    2'd2, P_ACC_LAST,  1'b1);
      default: s = mk(X_T,    Y_T,    2'd0, P_NONE,      1'b1);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/pgi_mac.sv =====
// Shared signed multiplier with registered product and a wide accumulator.
module pgi_mac (
  input  logic                               clk,
  input  pgi_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [pgi_pkg::X_W-1:0]     x,
  input  logic signed [pgi_pkg::Y_W-1:0]     y,
  output logic signed [pgi_pkg::PROD_W-1:0]  prod,
  output logic signed [pgi_pkg::ACC_W-1:0]   sum
);

  logic signed [pgi_pkg::ACC_W-1:0] acc;
  logic signed [pgi_pkg::ACC_W-1:0] prod_ext;

  assign prod_ext = {{(pgi_pkg::ACC_W - pgi_pkg::PROD_W){prod[pgi_pkg::PROD_W-1]}}, prod};
  assign sum      = acc + prod_ext;

  always_ff @(posedge clk) begin
    prod <= x * y;
    if (ctrl.acc_load) begin
      acc <= prod_ext;
    end else if (ctrl.acc_add) begin
      acc <= sum;
    end
  end

endmodule

// ===== rtl/palette_gradient_interpolator.sv =====
// Top level: palette memory, step sequencer and result register.
//
//  channel   signals                                    role
//  s_axis    tvalid tready tdata[111:0] tuser[1:0]      items in (action in tuser)
//  m_axis    tvalid tready tdata[23:0]  tuser[0]        results out (used_default in tuser)
//  cfg       cfg_we cfg_index cfg_wdata[23:0]           register writes
//
// From accept to the next possible accept, writes and default results pass through the accept
// and S_DONE; position, linear and bezier items pass through the accept, S_RD1 to S_RD3 reading the
// two entries through the single memory read port, one multiply a cycle on the shared
// multiplier (4 steps for linear, 19 for bezier), and S_DONE loading the output register.
// s_axis_tready is high only while the sequencer is idle; a result waiting in the output
// register stalls the sequencer in its final state. rst is synchronous; palette contents
// are not cleared.
module palette_gradient_interpolator #(
  parameter int PALETTE_DEPTH = pgi_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // first_index, second_index, position, fraction, control_a, control_b, entry_colour
  input  logic [pgi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // colour_out
  output logic [pgi_pkg::COLOUR_W-1:0]       m_axis_tdata,
  // used_default
  output logic                               m_axis_tuser,
  input  logic                               cfg_we,
  input  logic [pgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pgi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [31:0] DEPTH_U = 32'(PALETTE_DEPTH);
  localparam logic [pgi_pkg::CNT_W-1:0] DEPTH_CAP =
    pgi_pkg::CNT_W'((PALETTE_DEPTH > 127) ? 127 : PALETTE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_RD2  = 6'b000100,
    S_RD3  = 6'b001000,
    S_RUN  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [pgi_pkg::CNT_W-1:0]    palette_count;
  logic [pgi_pkg::COLOUR_W-1:0] default_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count  <= '0;
      default_colour <= 24'hFFFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        pgi_pkg::REG_PALETTE_COUNT:  palette_count  <= cfg_wdata[pgi_pkg::CNT_W-1:0];
        pgi_pkg::REG_DEFAULT_COLOUR: default_colour <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input fields
  logic [pgi_pkg::CNT_W-1:0]           in_first, in_second;
  logic [pgi_pkg::POS_W-1:0]           in_pos;
  logic [pgi_pkg::FRAC_W-1:0]          in_frac;
  logic signed [pgi_pkg::CTRL_W-1:0]   in_ca, in_cb;
  logic [pgi_pkg::COLOUR_W-1:0]        in_colour;
  pgi_pkg::action_t                    in_act;

  assign in_first  = s_axis_tdata[6:0];
  assign in_second = s_axis_tdata[13:7];
  assign in_pos    = s_axis_tdata[32:14];
  assign in_frac   = s_axis_tdata[49:33];
  assign in_ca     = s_axis_tdata[68:50];
  assign in_cb     = s_axis_tdata[87:69];
  assign in_colour = s_axis_tdata[111:88];
  assign in_act    = pgi_pkg::action_t'(s_axis_tuser);

  logic accept;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // decode at accept
  logic [pgi_pkg::CNT_W-1:0]  n_eff;
  logic [pgi_pkg::FRAC_W-1:0] t_clamp;
  logic [16:0]                pmax, pos_clamp;
  logic [pgi_pkg::CNT_W-1:0]  pos_lo, pos_hi;
  logic [9:0]                 pos_fr;
  logic                       wr_in_range, pair_ok;

  always_comb begin
    n_eff   = (palette_count > DEPTH_CAP) ? DEPTH_CAP : palette_count;
    t_clamp = (in_frac > pgi_pkg::T_ONE) ? pgi_pkg::T_ONE : in_frac;
    pmax    = {n_eff - 7'd1, 10'b0};
    if (in_pos[pgi_pkg::POS_W-1]) begin
      pos_clamp = '0;
    end else if (in_pos[17:0] > {1'b0, pmax}) begin
      pos_clamp = pmax;
    end else begin
      pos_clamp = in_pos[16:0];
    end
    pos_lo      = pos_clamp[16:10];
    pos_fr      = pos_clamp[9:0];
    pos_hi      = pos_lo + {6'b0, |pos_fr};
    wr_in_range = ({25'b0, in_first} < DEPTH_U);
    pair_ok     = (in_first < n_eff) && (in_second < n_eff);
  end

  // palette memory
  logic [pgi_pkg::COLOUR_W-1:0] mem [PALETTE_DEPTH];
  logic [pgi_pkg::COLOUR_W-1:0] rd_data;
  logic [IDX_W-1:0]             idx1, idx2, rd_addr;
  logic                         mem_we;

  assign mem_we  = accept && (in_act == pgi_pkg::ACT_WRITE) && wr_in_range;
  assign rd_addr = (state == S_RD1) ? idx1 : idx2;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(in_first)] <= in_colour;
    end
    rd_data <= mem[rd_addr];
  end

  // item registers
  logic [pgi_pkg::FRAC_W-1:0]        tv, uv;
  logic signed [pgi_pkg::CTRL_W-1:0] ca, cb;
  logic [pgi_pkg::COLOUR_W-1:0]      c1, c2, res_colour;
  logic                              dflt;
  logic [pgi_pkg::PC_W-1:0]          pc;
  logic [1:0]                        prev_ch;
  logic [pgi_pkg::W_W-1:0]           u2, t2, w0, w1, w2, w3;

  // shared multiplier
  pgi_pkg::ustep_t                      step;
  pgi_pkg::mac_ctrl_t                   mac_ctrl;
  logic signed [pgi_pkg::X_W-1:0]       mx;
  logic signed [pgi_pkg::Y_W-1:0]       my;
  logic signed [pgi_pkg::PROD_W-1:0]    prod;
  logic signed [pgi_pkg::ACC_W-1:0]     sum;
  logic [7:0]                           a_ch, b_ch, a_prev;
  logic signed [8:0]                    diff;
  logic [54:0]                          prod3;
  logic [24:0]                          lin_val;
  logic [7:0]                           bez_sat;

  assign step = pgi_pkg::ucode(pc);

  always_comb begin
    a_ch   = c1[{step.ch, 3'b000} +: 8];
    b_ch   = c2[{step.ch, 3'b000} +: 8];
    a_prev = c1[{prev_ch, 3'b000} +: 8];
    diff   = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});

    case (step.xsel)
      pgi_pkg::X_T:    mx = {17'b0, tv};
      pgi_pkg::X_U:    mx = {17'b0, uv};
      pgi_pkg::X_PROD: mx = {1'b0, prod[pgi_pkg::W_W-1:0]};
      pgi_pkg::X_U2:   mx = {1'b0, u2};
      pgi_pkg::X_T2:   mx = {1'b0, t2};
      pgi_pkg::X_W0:   mx = {1'b0, w0};
      pgi_pkg::X_W1:   mx = {1'b0, w1};
      pgi_pkg::X_W2:   mx = {1'b0, w2};
      pgi_pkg::X_W3:   mx = {1'b0, w3};
      default:         mx = '0;
    endcase

    case (step.ysel)
      pgi_pkg::Y_T:    my = {2'b0, tv};
      pgi_pkg::Y_U:    my = {2'b0, uv};
      pgi_pkg::Y_DIFF: my = {{10{diff[8]}}, diff};
      pgi_pkg::Y_A:    my = {3'b0, a_ch, 8'b0};
      pgi_pkg::Y_B:    my = {3'b0, b_ch, 8'b0};
      pgi_pkg::Y_CA:   my = ca;
      pgi_pkg::Y_CB:   my = cb;
      default:         my = '0;
    endcase

    mac_ctrl.acc_load = (state == S_RUN) && (step.post == pgi_pkg::P_ACC_FIRST);
    mac_ctrl.acc_add  = (state == S_RUN) && (step.post == pgi_pkg::P_ACC_ADD);

    // 3*p for the middle weights; p is non-negative there
    prod3   = {2'b0, prod} + {1'b0, prod, 1'b0};
    lin_val = {1'b0, a_prev, 16'b0} + prod[24:0];

    // truncate toward zero, then saturate: any negative sum gives 0
    if (sum[pgi_pkg::ACC_W-1]) begin
      bez_sat = 8'd0;
    end else if (|sum[pgi_pkg::ACC_W-2:pgi_pkg::BEZ_SHIFT+8]) begin
      bez_sat = 8'd255;
    end else begin
      bez_sat = sum[pgi_pkg::BEZ_SHIFT +: 8];
    end
  end

  pgi_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .x    (mx),
    .y    (my),
    .prod (prod),
    .sum  (sum)
  );

  // sequencer
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_act == pgi_pkg::ACT_WRITE) begin
            state_next = S_DONE;
          end else if (in_act == pgi_pkg::ACT_POS) begin
            state_next = (n_eff != '0) ? S_RD1 : S_DONE;
          end else begin
            state_next = pair_ok ? S_RD1 : S_DONE;
          end
        end
      end
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_RD3;
      S_RD3:  state_next = S_RUN;
      S_RUN:  state_next = step.last ? S_DONE : S_RUN;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          ca <= in_ca;
          cb <= in_cb;
          pc <= (in_act == pgi_pkg::ACT_BEZ) ? pgi_pkg::BEZ_START : pgi_pkg::LIN_START;
          if (in_act == pgi_pkg::ACT_WRITE) begin
            res_colour <= in_colour;
          end else begin
            res_colour <= default_colour;
          end
          if (in_act == pgi_pkg::ACT_POS) begin
            idx1 <= IDX_W'(pos_lo);
            idx2 <= IDX_W'(pos_hi);
            tv   <= {1'b0, pos_fr, 6'b0};
            uv   <= pgi_pkg::T_ONE - {1'b0, pos_fr, 6'b0};
          end else begin
            idx1 <= IDX_W'(in_first);
            idx2 <= IDX_W'(in_second);
            tv   <= t_clamp;
            uv   <= pgi_pkg::T_ONE - t_clamp;
          end
          case (in_act)
            pgi_pkg::ACT_WRITE: dflt <= 1'b0;
            pgi_pkg::ACT_POS:   dflt <= (n_eff == '0);
            default:            dflt <= !pair_ok;
          endcase
        end
      end
      S_RD2: c1 <= rd_data;
      S_RD3: c2 <= rd_data;
      S_RUN: begin
        prev_ch <= step.ch;
        if (!step.last) begin
          pc <= pc + 1'b1;
        end
        case (step.post)
          pgi_pkg::P_U2:       u2 <= prod[pgi_pkg::W_W-1:0];
          pgi_pkg::P_T2:       t2 <= prod[pgi_pkg::W_W-1:0];
          pgi_pkg::P_W0:       w0 <= prod[48:16];
          pgi_pkg::P_W1:       w1 <= prod3[48:16];
          pgi_pkg::P_W2:       w2 <= prod3[48:16];
          pgi_pkg::P_W3:       w3 <= prod[48:16];
          pgi_pkg::P_LIN:      res_colour[{prev_ch, 3'b000} +: 8] <= lin_val[23:16];
          pgi_pkg::P_ACC_LAST: res_colour[{prev_ch, 3'b000} +: 8] <= bez_sat;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_axis_tdata <= res_colour;
      m_axis_tuser <= dflt;
    end
  end

endmodule
